@@ rtl/pid_position_to_pwm_duty_assert.svh @@
// assertion macros for the pid position to pwm duty block
`ifndef PID_POSITION_TO_PWM_DUTY_ASSERT_SVH
`define PID_POSITION_TO_PWM_DUTY_ASSERT_SVH

`ifndef NO_ASSERTIONS

// implication checked at every edge outside reset
`define PIDPWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on a registered value against its previous value
`define PIDPWM_ASSERT_PAST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`else

`define PIDPWM_ASSERT(lbl, prop, msg)
`define PIDPWM_ASSERT_PAST(lbl, prop, msg)

`endif

`endif

@@ rtl/pidpwm_pkg.sv @@
// shared types, constants and helpers of the pid position to pwm duty block
`default_nettype none

package pidpwm_pkg;

  // sample period of the loop in integrator units
  localparam int STEP_TIME = 1000;

  // shared multiplier geometry
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;

  // reciprocal for division by the step time: q0 = (x * DIV_MAGIC) >> DIV_SHIFT
  localparam int DIV_SHIFT = 32 + $clog2(STEP_TIME + 1) - 1;
  localparam logic [63:0] DIV_MAGIC = (64'd1 << DIV_SHIFT) / 64'(STEP_TIME);
  localparam logic signed [MUL_W-1:0] DIV_MAGIC_OPND = {1'b0, DIV_MAGIC[MUL_W-2:0]};
  localparam logic signed [MUL_W-1:0] STEP_OPND = MUL_W'(STEP_TIME);
  localparam logic signed [MUL_W-1:0] ONE_Q16_OPND = MUL_W'(65536);

  // configuration register indexes
  localparam logic [2:0] CFG_REF    = 3'd0;
  localparam logic [2:0] CFG_GAIN_P = 3'd1;
  localparam logic [2:0] CFG_GAIN_I = 3'd2;
  localparam logic [2:0] CFG_GAIN_D = 3'd3;
  localparam logic [2:0] CFG_SCALE  = 3'd4;
  localparam logic [2:0] CFG_PERIOD = 3'd5;

  localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] S32_MIN = PROD_W'(-64'sd2147483648);
  localparam logic signed [PROD_W-1:0] S48_MAX = PROD_W'(64'sd140737488355327);
  localparam logic signed [PROD_W-1:0] S48_MIN = PROD_W'(-64'sd140737488355328);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MUL_POS,
    ST_ACC_POS,
    ST_ERR,
    ST_MUL_INT,
    ST_INT_ACC,
    ST_MUL_DIV,
    ST_DIV_Q,
    ST_MUL_CHK,
    ST_DIV_FIX,
    ST_MUL_P,
    ST_MUL_IH,
    ST_MUL_IL,
    ST_MUL_D,
    ST_SUM_D,
    ST_U_SAT,
    ST_MUL_DUTY,
    ST_DUTY
  } state_t;

  // request to the shared multiplier
  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] x);
    logic signed [31:0] res;
    if (x > S32_MAX) begin
      res = 32'sh7fffffff;
    end else if (x < S32_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = x[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [PROD_W-1:0] x);
    logic signed [47:0] res;
    if (x > S48_MAX) begin
      res = 48'sh7fffffffffff;
    end else if (x < S48_MIN) begin
      res = 48'sh800000000000;
    end else begin
      res = x[47:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pidpwm_mul.sv @@
// shared signed multiplier with registered product
`default_nettype none

module pidpwm_mul
  import pidpwm_pkg::*;
(
  input  wire                      clk,
  input  wire mul_req_t            req,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [MUL_W-1:0] op_a;
  logic signed [MUL_W-1:0] op_b;

  assign op_a = req.a;
  assign op_b = req.b;

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pid_position_to_pwm_duty.sv @@
// top level of the pid position loop that turns encoder counts into pwm duty
// the result beat shows on out_tvalid after a sample beat is taken, once the output register is free
// a new sample is taken only once the sequencer is idle again, after it walks nine products
//   through the one shared 34x34 multiplier plus the add and saturate steps between them
// the first sample after reset only primes the count history and yields no beat
// reset (rst_n low, synchronous) restores register defaults and clears all loop history
`default_nettype none
`include "pid_position_to_pwm_duty_assert.svh"

module pid_position_to_pwm_duty
  import pidpwm_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  // sample channel
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [31:0] in_tdata,   // [31:0] encoder_count
  // result channel
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [79:0] out_tdata,  // [15:0] pwm duty, [47:16] control_effort,
                                  // [79:48] shaft angle
  // configuration writes
  input  wire         cfg_wen,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_wdata
);

  // sequencer
  state_t state_r, state_nxt;

  // configuration registers
  logic signed [31:0] ref_r;
  logic signed [31:0] gain_p_r;
  logic signed [31:0] gain_i_r;
  logic signed [31:0] gain_d_r;
  logic signed [31:0] scale_r;
  logic        [15:0] period_r;

  // loop history
  logic               primed_r, primed_nxt;
  logic        [31:0] prev_count_r, prev_count_nxt;
  logic signed [31:0] pos_r, pos_nxt;
  logic signed [47:0] integ_r, integ_nxt;
  logic signed [31:0] prev_err_r, prev_err_nxt;

  // working registers of one sample
  logic        [31:0] cnt_r, cnt_nxt;
  logic signed [31:0] err_r, err_nxt;
  logic        [32:0] mag_r, mag_nxt;     // magnitude of the error difference
  logic               neg_r, neg_nxt;
  logic        [32:0] q_r, q_nxt;         // quotient estimate
  logic signed [31:0] deriv_r, deriv_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic signed [31:0] u_r, u_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic        [15:0] duty_r, duty_nxt;
  logic signed [31:0] effort_r, effort_nxt;
  logic signed [31:0] out_pos_r, out_pos_nxt;

  // shared multiplier
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod_r;

  logic in_beat;
  logic fire;    // result written into the output register this cycle

  assign in_beat = in_tvalid && in_tready;
  assign fire    = (state_r == ST_DUTY) && (!out_valid_r || out_tready);

  pidpwm_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  // ------------------------------------------------------------------
  // next state
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat && primed_r) begin
          state_nxt = ST_MUL_POS;
        end
      end
      ST_MUL_POS:  state_nxt = ST_ACC_POS;
      ST_ACC_POS:  state_nxt = ST_ERR;
      ST_ERR:      state_nxt = ST_MUL_INT;
      ST_MUL_INT:  state_nxt = ST_INT_ACC;
      ST_INT_ACC:  state_nxt = ST_MUL_DIV;
      ST_MUL_DIV:  state_nxt = ST_DIV_Q;
      ST_DIV_Q:    state_nxt = ST_MUL_CHK;
      ST_MUL_CHK:  state_nxt = ST_DIV_FIX;
      ST_DIV_FIX:  state_nxt = ST_MUL_P;
      ST_MUL_P:    state_nxt = ST_MUL_IH;
      ST_MUL_IH:   state_nxt = ST_MUL_IL;
      ST_MUL_IL:   state_nxt = ST_MUL_D;
      ST_MUL_D:    state_nxt = ST_SUM_D;
      ST_SUM_D:    state_nxt = ST_U_SAT;
      ST_U_SAT:    state_nxt = ST_MUL_DUTY;
      ST_MUL_DUTY: state_nxt = ST_DUTY;
      ST_DUTY: begin
        // hold here while the previous result still waits downstream
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // sequencer outputs: ready and multiplier operands
  // ------------------------------------------------------------------
  always_comb begin
    in_tready = 1'b0;
    mul_req   = '{en: 1'b0, a: '0, b: '0};
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_MUL_POS: begin
        // radians per count times wrapped count difference
        mul_req = '{en: 1'b1, a: MUL_W'(scale_r),
                    b: MUL_W'($signed(cnt_r - prev_count_r))};
      end
      ST_MUL_INT: begin
        mul_req = '{en: 1'b1, a: MUL_W'(err_r), b: STEP_OPND};
      end
      ST_MUL_DIV: begin
        // reciprocal multiply for the derivative quotient
        mul_req = '{en: 1'b1, a: {1'b0, mag_r}, b: DIV_MAGIC_OPND};
      end
      ST_MUL_CHK: begin
        // back-multiply the estimate to get the remainder
        mul_req = '{en: 1'b1, a: {1'b0, q_r}, b: STEP_OPND};
      end
      ST_MUL_P: begin
        mul_req = '{en: 1'b1, a: MUL_W'(gain_p_r), b: MUL_W'(err_r)};
      end
      ST_MUL_IH: begin
        // upper 32 bits of the integral, arithmetic
        mul_req = '{en: 1'b1, a: MUL_W'(gain_i_r), b: MUL_W'($signed(integ_r[47:16]))};
      end
      ST_MUL_IL: begin
        // low 16 bits of the integral, unsigned
        mul_req = '{en: 1'b1, a: MUL_W'(gain_i_r), b: {18'b0, integ_r[15:0]}};
      end
      ST_MUL_D: begin
        mul_req = '{en: 1'b1, a: MUL_W'(gain_d_r), b: MUL_W'(deriv_r)};
      end
      ST_MUL_DUTY: begin
        // (u + one) times the period, floor-halved in the duty step
        mul_req = '{en: 1'b1, a: MUL_W'(u_r) + ONE_Q16_OPND, b: {18'b0, period_r}};
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // datapath
  // ------------------------------------------------------------------
  logic signed [32:0]       diff;       // error difference
  logic        [PROD_W-1:0] quo_shift;
  logic        [33:0]       rem;
  logic        [32:0]       q_fix;
  logic signed [33:0]       q_signed;
  logic signed [PROD_W-1:0] duty_raw;

  always_comb begin
    primed_nxt     = primed_r;
    prev_count_nxt = prev_count_r;
    pos_nxt        = pos_r;
    integ_nxt      = integ_r;
    prev_err_nxt   = prev_err_r;
    cnt_nxt        = cnt_r;
    err_nxt        = err_r;
    mag_nxt        = mag_r;
    neg_nxt        = neg_r;
    q_nxt          = q_r;
    deriv_nxt      = deriv_r;
    acc_nxt        = acc_r;
    u_nxt          = u_r;
    duty_nxt       = duty_r;
    effort_nxt     = effort_r;
    out_pos_nxt    = out_pos_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    diff      = 33'(err_r) - 33'(prev_err_r);
    quo_shift = prod_r >> DIV_SHIFT;
    rem       = {1'b0, mag_r} - prod_r[33:0];
    q_fix     = (rem >= 34'(STEP_TIME)) ? q_r + 33'd1 : q_r;
    q_signed  = neg_r ? -$signed({1'b0, q_fix}) : $signed({1'b0, q_fix});
    duty_raw  = prod_r >>> 17;

    case (state_r) inside
      ST_IDLE: begin
        if (in_beat) begin
          if (!primed_r) begin
            // first sample only seeds the count history
            prev_count_nxt = in_tdata;
            primed_nxt     = 1'b1;
          end else begin
            cnt_nxt = in_tdata;
          end
        end
      end
      ST_ACC_POS: begin
        pos_nxt = sat32(PROD_W'(pos_r) + prod_r);
      end
      ST_ERR: begin
        err_nxt = sat32(PROD_W'(ref_r) - PROD_W'(pos_r));
      end
      ST_INT_ACC: begin
        integ_nxt = sat48(PROD_W'(integ_r) + prod_r);
        neg_nxt   = diff[32];
        mag_nxt   = diff[32] ? 33'(-diff) : 33'(diff);
      end
      ST_DIV_Q: begin
        q_nxt = quo_shift[32:0];
      end
      ST_DIV_FIX: begin
        // estimate is at most one short, truncation toward zero via sign-magnitude
        deriv_nxt = sat32(PROD_W'(q_signed));
      end
      ST_MUL_IH: begin
        acc_nxt = prod_r >>> 16;                // proportional term
      end
      ST_MUL_IL: begin
        acc_nxt = acc_r + prod_r;               // integral upper part, already aligned
      end
      ST_MUL_D, ST_SUM_D: begin
        acc_nxt = acc_r + (prod_r >>> 16);      // integral low part, then derivative
      end
      ST_U_SAT: begin
        u_nxt = sat32(acc_r);
      end
      ST_DUTY: begin
        if (fire) begin
          if (duty_raw < 0) begin
            duty_nxt = 16'd0;
          end else if (duty_raw > PROD_W'(period_r)) begin
            duty_nxt = period_r;
          end else begin
            duty_nxt = duty_raw[15:0];
          end
          effort_nxt     = u_r;
          out_pos_nxt    = pos_r;
          out_valid_nxt  = 1'b1;
          prev_err_nxt   = err_r;
          prev_count_nxt = cnt_r;
        end
      end
      default: begin
      end
    endcase
  end

  // ------------------------------------------------------------------
  // registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      primed_r     <= 1'b0;
      prev_count_r <= '0;
      pos_r        <= '0;
      integ_r      <= '0;
      prev_err_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      primed_r     <= primed_nxt;
      prev_count_r <= prev_count_nxt;
      pos_r        <= pos_nxt;
      integ_r      <= integ_nxt;
      prev_err_r   <= prev_err_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    err_r     <= err_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    q_r       <= q_nxt;
    deriv_r   <= deriv_nxt;
    acc_r     <= acc_nxt;
    u_r       <= u_nxt;
    duty_r    <= duty_nxt;
    effort_r  <= effort_nxt;
    out_pos_r <= out_pos_nxt;
  end

  // configuration decode, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r    <= '0;
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      scale_r  <= 32'sd66;
      period_r <= 16'd1000;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_REF:    ref_r    <= cfg_wdata;
        CFG_GAIN_P: gain_p_r <= cfg_wdata;
        CFG_GAIN_I: gain_i_r <= cfg_wdata;
        CFG_GAIN_D: gain_d_r <= cfg_wdata;
        CFG_SCALE:  scale_r  <= cfg_wdata;
        CFG_PERIOD: period_r <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_pos_r, effort_r, duty_r};

  // ------------------------------------------------------------------
  // assertions
  // ------------------------------------------------------------------
  // a primed sample always starts the sequence
  `PIDPWM_ASSERT(a_primed_starts, (in_beat && primed_r) |=> (state_r == ST_MUL_POS), "primed sample did not start the sequence")
  // an unprimed sample only primes and yields no work
  `PIDPWM_ASSERT(a_prime_only, (in_beat && !primed_r) |=> (state_r == ST_IDLE && primed_r && !$rose(out_valid_r)), "priming sample produced work")
  // a new result only comes from the duty step
  `PIDPWM_ASSERT_PAST(a_result_src, $rose(out_valid_r) |-> ($past(state_r) == ST_DUTY), "result appeared outside the duty step")
  // duty stays within the configured period
  `PIDPWM_ASSERT(a_duty_range, out_valid_r |-> (duty_r <= period_r), "duty beyond period")

endmodule

`default_nettype wire
